// File: hdl/ifa_pkg.sv
// shared types, codes and constant tables for the integer to ascii formatter
// no dependencies; every other file imports this package
`timescale 1ns / 1ps

package ifa_pkg;

  typedef enum logic [1:0] {
    ACT_SDEC = 2'd0,
    ACT_UDEC = 2'd1,
    ACT_HEX  = 2'd2
  } action_code_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] value;
  } in_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_t;

  // classified job handed from the front to the back
  typedef struct packed {
    logic        neg;
    logic        hex;
    logic [31:0] mag;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_EMIT
  } state_t;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [15:0][7:0] DIGIT_CHARS = {
    8'h46, 8'h45, 8'h44, 8'h43, 8'h42, 8'h41, 8'h39, 8'h38,
    8'h37, 8'h36, 8'h35, 8'h34, 8'h33, 8'h32, 8'h31, 8'h30
  };

  function automatic logic [31:0] pow10(input logic [3:0] p);
    logic [31:0] r;
    case (p)
      4'd0:    r = 32'd1;
      4'd1:    r = 32'd10;
      4'd2:    r = 32'd100;
      4'd3:    r = 32'd1000;
      4'd4:    r = 32'd10000;
      4'd5:    r = 32'd100000;
      4'd6:    r = 32'd1000000;
      4'd7:    r = 32'd10000000;
      4'd8:    r = 32'd100000000;
      4'd9:    r = 32'd1000000000;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/ifa_front.sv
// front end: takes the command beat and classifies it into a job
// depends on ifa_pkg
`timescale 1ns / 1ps

module ifa_front import ifa_pkg::*; (
  input  logic      start,
  input  in_t       item,
  input  q_status_t qstat,
  output logic      busy,
  output logic      push,
  output job_t      job
);

  logic neg;
  logic hex;

  always_comb begin
    hex  = !(item.action inside {ACT_SDEC, ACT_UDEC});
    neg  = (item.action == ACT_SDEC) && item.value[31];
    busy = qstat.full;
    push = start && !qstat.full;
    job.neg = neg;
    job.hex = hex;
    // most negative value negates to itself, which reads right as unsigned
    job.mag = neg ? (~item.value + 32'd1) : item.value;
  end

endmodule

// File: hdl/ifa_queue.sv
// two entry job queue between front and back
// depends on ifa_pkg
`timescale 1ns / 1ps

module ifa_queue import ifa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  job_t      wdata,
  input  logic      pop,
  output job_t      rdata,
  output q_status_t qstat
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  assign rdata       = slots[rd_ptr];
  assign qstat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);

endmodule

// File: hdl/ifa_back.sv
// back end: turns a job into characters, most significant first
// depends on ifa_pkg
`timescale 1ns / 1ps

module ifa_back import ifa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t qstat,
  input  job_t      job,
  output logic      pop,
  output logic      strobe,
  output out_t      result
);

  state_t      state;
  state_t      state_next;
  logic [31:0] mag;
  logic [31:0] mag_next;
  logic        hex;
  logic        hex_next;
  logic        neg;
  logic        neg_next;
  logic [3:0]  pos;
  logic [3:0]  pos_next;

  logic [31:0] p10;
  logic [35:0] prod;
  logic [3:0]  dec_digit;
  logic [31:0] dec_sub;
  logic [3:0]  dec_top;
  logic [3:0]  hex_top;
  logic [3:0]  nib;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    hex <= hex_next;
    neg <= neg_next;
    pos <= pos_next;
  end

  // digit count and current digit, by parallel compares against constants
  always_comb begin
    p10       = pow10(pos);
    dec_digit = '0;
    dec_sub   = '0;
    dec_top   = '0;
    hex_top   = '0;
    for (int k = 1; k < 10; k++) begin
      prod = 36'(k) * {4'd0, p10};
      if ({4'd0, mag} >= prod) begin
        dec_digit = 4'(k);
        dec_sub   = prod[31:0];
      end
    end
    for (int i = 1; i < 10; i++) begin
      if (mag >= pow10(4'(i))) begin
        dec_top = dec_top + 4'd1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      if (mag[i*4 +: 4] != 4'd0) begin
        hex_top = 4'(i);
      end
    end
    nib = mag[{pos[2:0], 2'b00} +: 4];
  end

  always_comb begin
    state_next = state;
    mag_next   = mag;
    hex_next   = hex;
    neg_next   = neg;
    pos_next   = pos;
    pop        = 1'b0;
    strobe     = 1'b0;
    result     = '0;
    case (state)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop        = 1'b1;
          mag_next   = job.mag;
          hex_next   = job.hex;
          neg_next   = job.neg;
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        pos_next = hex ? hex_top : dec_top;
        if (neg) begin
          strobe           = 1'b1;
          result.char_code = CHAR_MINUS;
          result.last      = 1'b0;
        end
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        strobe           = 1'b1;
        result.char_code = DIGIT_CHARS[hex ? nib : dec_digit];
        result.last      = (pos == 4'd0);
        mag_next         = hex ? mag : mag - dec_sub;
        pos_next         = pos - 4'd1;
        if (pos == 4'd0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter: front, job queue and back
// depends on ifa_pkg, ifa_front, ifa_queue, ifa_back
//
//   channel  | ports                 | handshake
//   ---------+-----------------------+-----------------------------------
//   command  | start, busy, item     | beat taken when start && !busy
//   result   | strobe, result        | one beat per character, no stall
//
// the back takes a job from the queue in its idle state, finds the digit
// count in the setup state (and shows the minus sign when there is one),
// then emits one digit per cycle in the emit state.
// busy rises only when the two entry job queue is full.
// rst is synchronous and empties the queue and returns the back to idle.
`timescale 1ns / 1ps

module integer_to_ascii_formatter import ifa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  item,
  output logic strobe,
  output out_t result
);

  q_status_t qstat;
  logic      push;
  logic      pop;
  job_t      wjob;
  job_t      rjob;

  ifa_front u_front (
    .start (start),
    .item  (item),
    .qstat (qstat),
    .busy  (busy),
    .push  (push),
    .job   (wjob)
  );

  ifa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wjob),
    .pop   (pop),
    .rdata (rjob),
    .qstat (qstat)
  );

  ifa_back u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .job    (rjob),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// File: hdl/ifa_checker.sv
// port level checks for the integer to ascii formatter, bound to the top
// depends on ifa_pkg and integer_to_ascii_formatter
`timescale 1ns / 1ps

module ifa_checker import ifa_pkg::*; (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic strobe,
  input out_t result
);

  logic is_minus;

  assign is_minus = (result.char_code == CHAR_MINUS);

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!strobe && !busy))
    else $error("beat or busy straight after reset");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (is_minus
                || (result.char_code >= 8'h30 && result.char_code <= 8'h39)
                || (result.char_code >= 8'h41 && result.char_code <= 8'h46)))
    else $error("illegal character code");

  a_minus_leads: assert property (@(posedge clk) disable iff (rst)
    (strobe && is_minus) |-> !result.last ##1 (strobe && !is_minus))
    else $error("minus sign not followed by a digit");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !strobe)
    else $error("beat straight after the last character");

endmodule

bind integer_to_ascii_formatter ifa_checker u_ifa_checker (
  .clk    (clk),
  .rst    (rst),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);

// File: tb/integer_to_ascii_formatter_test.sv
// self-checking testbench for integer_to_ascii_formatter: directed and random numbers in
// every format mode, each character checked against an in-bench formatter
// depends on ifa_pkg and the rtl under hdl/
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test;
  import ifa_pkg::*;

  localparam logic [1:0] ACT_SPARE   = 2'd3;  // undefined mode, formats as hex
  localparam logic [7:0] ASCII_ZERO  = "0";
  localparam logic [7:0] ASCII_A     = "A";
  localparam logic [7:0] ASCII_MINUS = "-";
  localparam int         RANDOM_NUMS = 198;
  localparam int         TAIL_CYCLES = 30;

  logic clk = 1'b0;
  logic rst;
  logic start = 1'b0;
  logic busy;
  in_t  item = '0;
  logic strobe;
  out_t result;

  in_t  numbers_pending[$];
  bit   drain_first[$];     // hold the number back until every character is in
  out_t chars_due[$];
  logic taken = 1'b0;

  int   errors;
  int   numbers_sent;
  int   numbers_taken;
  int   chars_checked;
  int   mode_count [4];

  integer_to_ascii_formatter u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  always #5 clk = ~clk;

  // expected character sequence for one number, most significant first
  function automatic void format_number(input in_t cmd);
    logic [31:0] mag;
    logic [31:0] radix;
    logic        neg;
    logic [3:0]  d;
    logic [7:0]  rev [0:9];
    int          nd;
    out_t        ch;
    mag   = cmd.value;
    radix = 32'd10;
    neg   = 1'b0;
    nd    = 0;
    if (cmd.action == ACT_SDEC) begin
      if (mag[31]) begin
        neg = 1'b1;
        mag = -mag;
      end
    end else if (cmd.action != ACT_UDEC) begin
      radix = 32'd16;
    end
    do begin
      d = 4'(mag % radix);
      rev[nd] = (d < 4'd10) ? ASCII_ZERO + d : ASCII_A + d - 8'd10;
      nd++;
      mag = mag / radix;
    end while (mag != 0 && nd < 10);
    if (neg) begin
      ch.char_code = ASCII_MINUS;
      ch.last      = 1'b0;
      chars_due.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.char_code = rev[i];
      ch.last      = (i == 0);
      chars_due.push_back(ch);
    end
  endfunction

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    int unsigned p;
    case ($urandom_range(9))
      0, 1, 2: v = $urandom;
      3, 4:    v = $urandom >> $urandom_range(31);
      5:       v = $urandom_range(99);
      6: begin
        // around a power of ten, where the digit count changes
        p = $urandom_range(9);
        v = 32'd1;
        repeat (p) v = v * 10;
        v = v + $urandom_range(2) - 1;
      end
      7:       v = -$urandom_range(99);
      8:       v = (32'd1 << $urandom_range(31)) + $urandom_range(2) - 1;
      default: v = 32'h8000_0000 + $urandom_range(2) - 1;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_action();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel < 5)       return ACT_SDEC;
    else if (sel < 10) return ACT_UDEC;
    else if (sel < 15) return ACT_HEX;
    else               return ACT_SPARE;
  endfunction

  function automatic void queue_number(input logic [1:0] act, input logic [31:0] val,
                                       input bit drain);
    in_t cmd;
    cmd.action = act;
    cmd.value  = val;
    numbers_pending.push_back(cmd);
    drain_first.push_back(drain);
  endfunction

  // command driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (numbers_pending.size() != 0 && (!drain_first[0] || chars_due.size() == 0) &&
          ((numbers_sent >= 70 && numbers_sent < 140) || $urandom_range(99) >= 23)) begin
        item <= numbers_pending.pop_front();
        void'(drain_first.pop_front());
        start <= 1'b1;
        numbers_sent++;
      end else begin
        start <= 1'b0;
        item  <= {2'($urandom), $urandom};
      end
    end
  end

  // accepted beats feed the formatter, result beats are checked in order
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst) begin
      taken <= 1'b0;
    end else begin
      taken <= start && !busy;
      if (start && !busy) begin
        format_number(item);
        numbers_taken++;
        mode_count[item.action]++;
      end
      if (strobe) begin
        if (chars_due.size() == 0) begin
          $error("unexpected character %h last %b", result.char_code, result.last);
          errors++;
        end else begin
          want = chars_due.pop_front();
          chars_checked++;
          if (result.char_code !== want.char_code) begin
            $error("char_code: expected %h, got %h", want.char_code, result.char_code);
            errors++;
          end
          if (result.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, result.last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    errors = 0;
    numbers_sent = 0;
    numbers_taken = 0;
    chars_checked = 0;
    foreach (mode_count[i]) mode_count[i] = 0;

    // directed: zero and all-ones in every mode, the most negative value, digit boundaries
    queue_number(ACT_SDEC,  32'd0,          1'b0);
    queue_number(ACT_UDEC,  32'd0,          1'b0);
    queue_number(ACT_HEX,   32'd0,          1'b0);
    queue_number(ACT_SPARE, 32'd0,          1'b0);
    queue_number(ACT_SDEC,  32'hFFFF_FFFF,  1'b0);
    queue_number(ACT_UDEC,  32'hFFFF_FFFF,  1'b0);
    queue_number(ACT_HEX,   32'hFFFF_FFFF,  1'b0);
    queue_number(ACT_SPARE, 32'hFFFF_FFFF,  1'b0);
    queue_number(ACT_SDEC,  32'h8000_0000,  1'b0);
    queue_number(ACT_UDEC,  32'h8000_0000,  1'b0);
    queue_number(ACT_HEX,   32'h8000_0000,  1'b0);
    queue_number(ACT_SDEC,  32'h7FFF_FFFF,  1'b0);
    queue_number(ACT_SDEC,  32'h8000_0001,  1'b0);
    queue_number(ACT_SDEC,  32'd1,          1'b0);
    queue_number(ACT_UDEC,  32'd9,          1'b0);
    queue_number(ACT_UDEC,  32'd10,         1'b0);
    queue_number(ACT_HEX,   32'd15,         1'b0);
    queue_number(ACT_HEX,   32'd16,         1'b0);
    queue_number(ACT_UDEC,  32'd999999999,  1'b0);
    queue_number(ACT_UDEC,  32'd1000000000, 1'b0);
    queue_number(ACT_HEX,   32'hDEAD_BEEF,  1'b0);
    queue_number(ACT_SPARE, 32'hABCD_EF01,  1'b0);

    for (int n = 0; n < RANDOM_NUMS; n++)
      queue_number(pick_action(), pick_value(), (n % 50) == 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (numbers_pending.size() != 0 || start) @(posedge clk);
    while (chars_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb: %0d numbers formatted (signed %0d, unsigned %0d, hex %0d, spare mode %0d)",
             numbers_taken, mode_count[ACT_SDEC], mode_count[ACT_UDEC],
             mode_count[ACT_HEX], mode_count[ACT_SPARE]);
    $display("tb: %0d characters checked, %0d mismatches", chars_checked, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
